@@ hw/rtl/lpdx_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lpdx_pkg;

    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 7;
    localparam int IDX_W           = 6;
    localparam int COUNT_W         = 32;
    localparam int PAYLOAD_MAX_DEF = 64;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_DATA  = 2'd0;
    localparam kind_t KIND_EMPTY = 2'd1;
    localparam kind_t KIND_BAD   = 2'd2;

endpackage

`default_nettype wire

@@ hw/rtl/lpdx_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface lpdx_in_if;
    import lpdx_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

`default_nettype wire

@@ hw/rtl/lpdx_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface lpdx_out_if;
    import lpdx_pkg::*;

    logic               valid;
    logic               ready;
    kind_t              kind;
    logic [BYTE_W-1:0]  frame_type;
    logic [LEN_W-1:0]   frame_length;
    logic [BYTE_W-1:0]  data_byte;
    logic [IDX_W-1:0]   byte_index;
    logic               last;
    logic [COUNT_W-1:0] bad_frame_count;

    modport source (output valid, output kind, output frame_type, output frame_length,
                    output data_byte, output byte_index, output last,
                    output bad_frame_count, input ready);
    modport sink   (input valid, input kind, input frame_type, input frame_length,
                    input data_byte, input byte_index, input last,
                    input bad_frame_count, output ready);

endinterface

`default_nettype wire

@@ hw/rtl/length_prefixed_deframer_xor_check_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Header, type and payload bytes are taken whenever rx.valid is high; rx.ready stays high between frames.
// Bad or empty frame: one result, registered in the cycle after the check byte is accepted.
// Good frame: the first payload result passes the RAM read register and then the result register,
// then one per cycle while the result channel does not stall (payload RAM with separate read and
// write ports, one read per cycle); rx.ready is low while the payload is replayed.
// rst_n (async, active low) clears control state, counters and start_byte;
// the payload RAM is not cleared.
module length_prefixed_deframer_xor_check_core #(
    parameter int PAYLOAD_MAX = lpdx_pkg::PAYLOAD_MAX_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lpdx_pkg::BYTE_W-1:0] cfg_wdata,
    lpdx_in_if.sink                     rx,
    lpdx_out_if.source                  res
);
    import lpdx_pkg::*;

    localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam int CW = $clog2(PAYLOAD_MAX + 1);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_TYPE    = 3'd1;
    localparam logic [2:0] PH_LEN_LO  = 3'd2;
    localparam logic [2:0] PH_LEN_HI  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CHECK   = 3'd5;
    localparam logic [2:0] PH_REPLAY  = 3'd6;

    logic [2:0]         phase_reg,      phase_next;
    logic [BYTE_W-1:0]  start_byte_reg;
    logic [BYTE_W-1:0]  type_reg,       type_next;
    logic [BYTE_W-1:0]  xor_reg,        xor_next;
    logic [BYTE_W-1:0]  len_lo_reg,     len_lo_next;
    logic [CW-1:0]      exp_len_reg,    exp_len_next;
    logic [CW-1:0]      cnt_reg,        cnt_next;
    logic [COUNT_W-1:0] bad_reg,        bad_next;
    logic               rd_pend_reg,    rd_pend_next;
    logic [CW-1:0]      rd_cnt_reg,     rd_cnt_next;
    logic               res_valid_reg,  res_valid_next;

    kind_t              kind_reg,       kind_next;
    logic [LEN_W-1:0]   flen_reg,       flen_next;
    logic [BYTE_W-1:0]  data_reg,       data_next;
    logic [IDX_W-1:0]   idx_reg,        idx_next;
    logic               last_reg,       last_next;
    logic [COUNT_W-1:0] cnt_out_reg,    cnt_out_next;
    logic [BYTE_W-1:0]  ftype_reg;

    logic               load_out;
    logic               slot_free;
    logic               rx_fire;
    logic [BYTE_W-1:0]  b;
    logic [15:0]        full_len;
    logic [CW-1:0]      cnt_plus;
    logic [CW-1:0]      rd_cnt_plus;

    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [BYTE_W-1:0]  ram_rdata;

    assign slot_free   = !res_valid_reg || res.ready;
    assign rx.ready    = (phase_reg != PH_REPLAY) && ((phase_reg != PH_CHECK) || slot_free);
    assign rx_fire     = rx.valid && rx.ready;
    assign b           = rx.rx_byte;
    assign full_len    = {b, len_lo_reg};
    assign cnt_plus    = cnt_reg + CW'(1);
    assign rd_cnt_plus = rd_cnt_reg + CW'(1);
    assign ram_we      = rx_fire && (phase_reg == PH_PAYLOAD);

    always_comb
    begin
        phase_next     = phase_reg;
        type_next      = type_reg;
        xor_next       = xor_reg;
        len_lo_next    = len_lo_reg;
        exp_len_next   = exp_len_reg;
        cnt_next       = cnt_reg;
        bad_next       = bad_reg;
        rd_pend_next   = rd_pend_reg;
        rd_cnt_next    = rd_cnt_reg;
        res_valid_next = res_valid_reg && !res.ready;
        load_out       = 1'b0;
        kind_next      = KIND_DATA;
        flen_next      = LEN_W'(exp_len_reg);
        data_next      = '0;
        idx_next       = '0;
        last_next      = 1'b1;
        cnt_out_next   = bad_reg;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        unique case (phase_reg)
            PH_TYPE:
            begin
                if (rx_fire)
                begin
                    type_next  = b;
                    xor_next   = b;
                    phase_next = PH_LEN_LO;
                end
            end
            PH_LEN_LO:
            begin
                if (rx_fire)
                begin
                    len_lo_next = b;
                    xor_next    = xor_reg ^ b;
                    phase_next  = PH_LEN_HI;
                end
            end
            PH_LEN_HI:
            begin
                if (rx_fire)
                begin
                    xor_next     = xor_reg ^ b;
                    cnt_next     = '0;
                    // oversized length drops back to the hunt without a result
                    if (full_len > 16'(PAYLOAD_MAX))
                    begin
                        phase_next = PH_HUNT;
                    end
                    else if (full_len == 16'd0)
                    begin
                        exp_len_next = '0;
                        phase_next   = PH_CHECK;
                    end
                    else
                    begin
                        exp_len_next = full_len[CW-1:0];
                        phase_next   = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (rx_fire)
                begin
                    xor_next = xor_reg ^ b;
                    cnt_next = cnt_plus;
                    if (cnt_plus >= exp_len_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
            end
            PH_CHECK:
            begin
                if (rx_fire)
                begin
                    phase_next = PH_HUNT;
                    if (b != xor_reg)
                    begin
                        bad_next       = bad_reg + COUNT_W'(1);
                        load_out       = 1'b1;
                        res_valid_next = 1'b1;
                        kind_next      = KIND_BAD;
                        cnt_out_next   = bad_reg + COUNT_W'(1);
                    end
                    else if (exp_len_reg == '0)
                    begin
                        load_out       = 1'b1;
                        res_valid_next = 1'b1;
                        kind_next      = KIND_EMPTY;
                    end
                    else
                    begin
                        // prime the RAM with entry 0; results follow from the read data
                        ram_re       = 1'b1;
                        rd_pend_next = 1'b1;
                        rd_cnt_next  = '0;
                        phase_next   = PH_REPLAY;
                    end
                end
            end
            PH_REPLAY:
            begin
                if (rd_pend_reg && slot_free)
                begin
                    load_out       = 1'b1;
                    res_valid_next = 1'b1;
                    kind_next      = KIND_DATA;
                    data_next      = ram_rdata;
                    idx_next       = IDX_W'(rd_cnt_reg);
                    last_next      = (rd_cnt_plus == exp_len_reg);
                    if (rd_cnt_plus < exp_len_reg)
                    begin
                        ram_re      = 1'b1;
                        ram_raddr   = rd_cnt_plus[AW-1:0];
                        rd_cnt_next = rd_cnt_plus;
                    end
                    else
                    begin
                        rd_pend_next = 1'b0;
                        phase_next   = PH_HUNT;
                    end
                end
            end
            default:
            begin
                // hunt; the unused code acts the same
                if (rx_fire)
                begin
                    phase_next = (b == start_byte_reg) ? PH_TYPE : PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            start_byte_reg <= '0;
            type_reg       <= '0;
            xor_reg        <= '0;
            len_lo_reg     <= '0;
            exp_len_reg    <= '0;
            cnt_reg        <= '0;
            bad_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            rd_cnt_reg     <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            type_reg      <= type_next;
            xor_reg       <= xor_next;
            len_lo_reg    <= len_lo_next;
            exp_len_reg   <= exp_len_next;
            cnt_reg       <= cnt_next;
            bad_reg       <= bad_next;
            rd_pend_reg   <= rd_pend_next;
            rd_cnt_reg    <= rd_cnt_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                start_byte_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            kind_reg    <= kind_next;
            ftype_reg   <= type_reg;
            flen_reg    <= flen_next;
            data_reg    <= data_next;
            idx_reg     <= idx_next;
            last_reg    <= last_next;
            cnt_out_reg <= cnt_out_next;
        end
    end

    lpdx_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAYLOAD_MAX)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (b),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res.valid           = res_valid_reg;
    assign res.kind            = kind_reg;
    assign res.frame_type      = ftype_reg;
    assign res.frame_length    = flen_reg;
    assign res.data_byte       = data_reg;
    assign res.byte_index      = idx_reg;
    assign res.last            = last_reg;
    assign res.bad_frame_count = cnt_out_reg;

    a_pend_only_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (phase_reg == PH_REPLAY))
        else $error("RAM read pending outside replay");

    a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        exp_len_reg <= CW'(PAYLOAD_MAX))
        else $error("stored frame length exceeds payload buffer");

    a_bad_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_fire && (phase_reg == PH_CHECK) && (rx.rx_byte != xor_reg))
        |=> (bad_reg == $past(bad_reg) + COUNT_W'(1)))
        else $error("bad-frame count did not advance on check mismatch");

    a_index_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.kind == KIND_DATA)) |-> ({1'b0, res.byte_index} < res.frame_length))
        else $error("payload index beyond frame length");

endmodule

`default_nettype wire

@@ hw/rtl/lpdx_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpdx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_length_prefixed_deframer_xor_check_core.sv @@
`timescale 1ns / 1ps

module tb_length_prefixed_deframer_xor_check_core;
    import lpdx_pkg::*;

    localparam int PAYLOAD_MAX   = PAYLOAD_MAX_DEF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int BYTES_PER_SET = 45;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [2:0] {
        P_HUNT    = 3'd0,
        P_TYPE    = 3'd1,
        P_LEN_LO  = 3'd2,
        P_LEN_HI  = 3'd3,
        P_PAYLOAD = 3'd4,
        P_CHECK   = 3'd5
    } parse_phase_t;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_t;

    typedef struct {
        kind_t              kind;
        logic [BYTE_W-1:0]  frame_type;
        logic [LEN_W-1:0]   frame_length;
        logic [BYTE_W-1:0]  data_byte;
        logic [IDX_W-1:0]   byte_index;
        logic               last;
        logic [COUNT_W-1:0] bad_frame_count;
    } frame_result_t;

    class frame_scoreboard;
        logic [7:0]         start_value;
        parse_phase_t       phase;
        logic [7:0]         held_type;
        logic [7:0]         run_xor;
        logic [15:0]        want_len;
        logic [6:0]         got_count;
        logic [7:0]         payload [PAYLOAD_MAX];
        logic [31:0]        bad_frames;
        frame_result_t      expected_q [$];
        int                 errors;

        function new();
            start_value = 8'h00;
            phase       = P_HUNT;
            held_type   = 8'h00;
            run_xor     = 8'h00;
            want_len    = 16'h0000;
            got_count   = 7'd0;
            bad_frames  = 32'd0;
            errors      = 0;
        endfunction

        function void set_start(logic [7:0] v);
            start_value = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_result(kind_t k, logic [7:0] d, int idx, logic lst);
            frame_result_t r;
            r.kind            = k;
            r.frame_type      = held_type;
            r.frame_length    = (k == KIND_EMPTY) ? 7'd0 : want_len[6:0];
            r.data_byte       = d;
            r.byte_index      = idx[5:0];
            r.last            = lst;
            r.bad_frame_count = bad_frames;
            expected_q.push_back(r);
        endfunction

        // Accepted input transaction: advance the parser, queue what it produces.
        function void take_byte(logic [7:0] b);
            int i;
            case (phase)
                P_TYPE:
                begin
                    held_type = b;
                    run_xor   = b;
                    phase     = P_LEN_LO;
                end
                P_LEN_LO:
                begin
                    want_len = {8'h00, b};
                    run_xor ^= b;
                    phase    = P_LEN_HI;
                end
                P_LEN_HI:
                begin
                    want_len[15:8] = b;
                    run_xor ^= b;
                    got_count = 7'd0;
                    if (want_len > PAYLOAD_MAX)
                        phase = P_HUNT;
                    else
                        phase = (want_len == 0) ? P_CHECK : P_PAYLOAD;
                end
                P_PAYLOAD:
                begin
                    payload[got_count[5:0]] = b;
                    run_xor ^= b;
                    got_count = got_count + 7'd1;
                    if (got_count >= want_len)
                        phase = P_CHECK;
                end
                P_CHECK:
                begin
                    if (b == run_xor) begin
                        if (want_len == 0)
                            push_result(KIND_EMPTY, 8'h00, 0, 1'b1);
                        else
                            for (i = 0; i < want_len; i++)
                                push_result(KIND_DATA, payload[i], i, (i + 1 == want_len));
                    end else begin
                        bad_frames = bad_frames + 32'd1;
                        push_result(KIND_BAD, 8'h00, 0, 1'b1);
                    end
                    phase = P_HUNT;
                end
                default:
                begin
                    phase = (b == start_value) ? P_TYPE : P_HUNT;
                end
            endcase
        endfunction

        function void check_result(frame_result_t got);
            frame_result_t want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: kind %0d type %0h", got.kind, got.frame_type);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.frame_type !== want.frame_type) begin
                $error("frame_type: expected %0h, got %0h", want.frame_type, got.frame_type);
                errors++;
            end
            if (got.frame_length !== want.frame_length) begin
                $error("frame_length: expected %0d, got %0d",
                       want.frame_length, got.frame_length);
                errors++;
            end
            if (got.data_byte !== want.data_byte) begin
                $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
                errors++;
            end
            if (got.byte_index !== want.byte_index) begin
                $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
            if (got.bad_frame_count !== want.bad_frame_count) begin
                $error("bad_frame_count: expected %0d, got %0d",
                       want.bad_frame_count, got.bad_frame_count);
                errors++;
            end
        endfunction
    endclass

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cfg_we     = 1'b0;
    logic [7:0] cfg_wdata  = 8'h00;
    logic       src_valid  = 1'b0;
    logic [7:0] src_byte   = 8'h00;
    logic       sink_ready = 1'b0;

    lpdx_in_if  rx_if ();
    lpdx_out_if res_if ();

    assign rx_if.valid  = src_valid;
    assign rx_if.rx_byte = src_byte;
    assign res_if.ready = sink_ready;

    length_prefixed_deframer_xor_check_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rx        (rx_if),
        .res       (res_if)
    );

    frame_scoreboard sb = new();

    int          cycle_count = 0;
    int          burst_left  = 0;
    stall_mode_t sink_mode   = STALL_NONE;
    int          mode_left   = 0;
    int          sink_tick   = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL length_prefixed_deframer_xor_check_core");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        frame_result_t got;
        if (rst_n) begin
            if (rx_if.valid && rx_if.ready)
                sb.take_byte(rx_if.rx_byte);
            if (res_if.valid && res_if.ready) begin
                got.kind            = res_if.kind;
                got.frame_type      = res_if.frame_type;
                got.frame_length    = res_if.frame_length;
                got.data_byte       = res_if.data_byte;
                got.byte_index      = res_if.byte_index;
                got.last            = res_if.last;
                got.bad_frame_count = res_if.bad_frame_count;
                sb.check_result(got);
            end
        end
    end

    // Receiver back-pressure, switching between stall styles every so often.
    always @(negedge clk)
    begin
        if (mode_left == 0) begin
            sink_mode = stall_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        sink_tick++;
        case (sink_mode)
            STALL_NONE:     sink_ready <= 1'b1;
            STALL_COIN:     sink_ready <= ($urandom_range(0, 1) == 1);
            STALL_PERIODIC: sink_ready <= (sink_tick % 3 != 0);
            default:        sink_ready <= ($urandom_range(0, 99) < 15);
        endcase
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        src_valid <= 1'b1;
        src_byte  <= b;
        forever begin
            @(posedge clk);
            if (rx_if.ready)
                break;
        end
        @(negedge clk);
    endtask

    task automatic wait_idle();
        src_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_start(input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        sb.set_start(v);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] sof, input logic [7:0] ftype,
                              input logic [15:0] len, input logic [7:0] chk_flip);
        logic [7:0] xsum;
        logic [7:0] b;
        int i;
        xsum = ftype ^ len[7:0] ^ len[15:8];
        send_byte(sof);
        send_byte(ftype);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        for (i = 0; i < len; i++) begin
            b = (i == 0 && len == 1) ? 8'h00 : (i == 0 ? 8'hFF : 8'h80);
            xsum ^= b;
            send_byte(b);
        end
        send_byte(xsum ^ chk_flip);
    endtask

    // One random transaction group: mostly well-formed frames, some broken ones and noise.
    task automatic send_random_group(ref int counted);
        logic [7:0] seq [$];
        logic [7:0] xsum;
        logic [7:0] b;
        logic [15:0] len;
        int pick;
        int lsel;
        int n;
        int i;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            n = $urandom_range(1, 3);
            counted += n;
            repeat (n) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        lsel = $urandom_range(0, 19);
        if (pick < 15)
            len = 16'($urandom_range(PAYLOAD_MAX + 1, 65535));
        else if (lsel < 2)
            len = 16'd0;
        else if (lsel == 2)
            len = 16'(PAYLOAD_MAX);
        else if (lsel == 3)
            len = 16'($urandom_range(9, PAYLOAD_MAX));
        else
            len = 16'($urandom_range(1, 8));
        b = 8'($urandom_range(0, 255));
        seq.push_back(sb.start_value);
        seq.push_back(b);
        seq.push_back(len[7:0]);
        seq.push_back(len[15:8]);
        xsum = b ^ len[7:0] ^ len[15:8];
        if (len <= PAYLOAD_MAX) begin
            for (i = 0; i < len; i++) begin
                b = 8'($urandom_range(0, 255));
                xsum ^= b;
                seq.push_back(b);
            end
            if (pick >= 15 && pick < 25)
                xsum ^= 8'($urandom_range(1, 255));
            seq.push_back(xsum);
            // Cut short: the next group's bytes land inside this frame.
            if (pick >= 25 && pick < 30)
                repeat ($urandom_range(1, seq.size() - 1)) void'(seq.pop_back());
        end
        counted += seq.size();
        foreach (seq[j])
            send_byte(seq[j]);
    endtask

    initial
    begin
        logic [7:0] set_starts [6];
        int counted;
        int s;
        set_starts[0] = 8'h00;
        set_starts[1] = 8'hFF;
        set_starts[2] = 8'($urandom_range(0, 255));
        set_starts[3] = 8'h7E;
        set_starts[4] = 8'($urandom_range(0, 255));
        set_starts[5] = 8'($urandom_range(0, 255));

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_start(8'hA5);
        // Empty frame whose check byte equals the start byte, then a stray byte.
        send_frame(8'hA5, 8'hA5, 16'd0, 8'h00);
        send_byte(8'h3C);
        send_frame(8'hA5, 8'hFF, 16'd1, 8'h00);
        send_frame(8'hA5, 8'h00, 16'd2, 8'h01);
        // Oversized lengths, low byte and high byte.
        send_byte(8'hA5);
        send_byte(8'h12);
        send_byte(8'h41);
        send_byte(8'h00);
        send_byte(8'hA5);
        send_byte(8'h12);
        send_byte(8'h00);
        send_byte(8'h01);
        wait_idle();

        for (s = 0; s < 6; s++) begin
            write_start(set_starts[s]);
            counted = 0;
            while (counted < BYTES_PER_SET)
                send_random_group(counted);
            wait_idle();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS length_prefixed_deframer_xor_check_core");
        else
            $display("FAIL length_prefixed_deframer_xor_check_core");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/lpdx_pkg.sv
hw/rtl/lpdx_in_if.sv
hw/rtl/lpdx_out_if.sv
hw/rtl/lpdx_ram.sv
hw/rtl/length_prefixed_deframer_xor_check_core.sv
tb/tb_length_prefixed_deframer_xor_check_core.sv
